>>> rtl/color_palette_indexer_assert.svh
`ifndef COLOR_PALETTE_INDEXER_ASSERT_SVH
`define COLOR_PALETTE_INDEXER_ASSERT_SVH

// Assertion macros: same-cycle and next-cycle implication on clk, off in reset.
`ifndef SYNTHESIS
`define CPI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("color_palette_indexer: check failed");
`define CPI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("color_palette_indexer: check failed");
`else
`define CPI_ASSERT_IMP(label, ante, cons)
`define CPI_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/cpi_pkg.sv
package cpi_pkg;

    localparam int COLOR_W = 24;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       last_pixel;
    } cpi_pixel_t;

    typedef struct packed {
        logic [7:0] color_index;
        logic       new_entry;
        logic       overflow;
        logic [8:0] entry_count;
        logic       last_result;
    } cpi_result_t;

    // search token walking down the cell row
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               last;
        logic [COLOR_W-1:0] color;
    } cpi_tok_t;

endpackage

>>> rtl/color_palette_indexer.sv
// Channel   Ports                  Handshake
// -------   --------------------   ------------------------------------------
// pixel     pixel (cpi_pixel_t)    taken at an edge with start high, busy low
// result    result (cpi_result_t)  valid for one cycle while done is high
//
// An item walks the cell row one cell per cycle: the result strobe is
// registered from the last cell's output, and busy drops in the strobe
// cycle, so a new item is not taken before the last one's strobe cycle.
// Reset clears the entry count; palette cells hold no reset value.
// The receiver takes every result in its strobe cycle.
`include "color_palette_indexer_assert.svh"

module color_palette_indexer
    import cpi_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cpi_pixel_t  pixel,
    output logic        done,
    output cpi_result_t result
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    cpi_tok_t         tok [PALETTE_DEPTH+1];
    logic [IDX_W-1:0] idx [PALETTE_DEPTH+1];

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    cpi_result_t      result_reg;
    cpi_result_t      result_next;

    cpi_tok_t         tail;
    logic [IDX_W-1:0] tail_idx;
    logic             accept;
    logic             full;
    logic             add;
    logic             ovf;
    logic [CNT_W-1:0] cnt_add;

    assign accept = start && !busy_reg;

    assign tok[0] = '{
        valid: accept,
        hit:   1'b0,
        last:  pixel.last_pixel,
        color: {pixel.pixel_red, pixel.pixel_green, pixel.pixel_blue}
    };
    assign idx[0] = '0;

    assign tail     = tok[PALETTE_DEPTH];
    assign tail_idx = idx[PALETTE_DEPTH];

    assign full    = count_reg == CNT_W'(PALETTE_DEPTH);
    assign add     = tail.valid && !tail.hit && !full;
    assign ovf     = !tail.hit && full;
    assign cnt_add = add ? CNT_W'(count_reg + 1'b1) : count_reg;

    for (genvar i = 0; i < PALETTE_DEPTH; i++)
    begin : g_cell
        cpi_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok[i]),
            .idx_in   (idx[i]),
            .count    (count_reg),
            .wr_en    (add),
            .wr_addr  (count_reg[IDX_W-1:0]),
            .wr_color (tail.color),
            .tok_out  (tok[i+1]),
            .idx_out  (idx[i+1])
        );
    end

    always_comb
    begin
        result_next.new_entry   = add;
        result_next.overflow    = ovf;
        result_next.entry_count = 9'(cnt_add);
        result_next.last_result = tail.last;
        if (tail.hit)
        begin
            result_next.color_index = 8'(tail_idx);
        end
        else if (add)
        begin
            result_next.color_index = 8'(count_reg);
        end
        else
        begin
            result_next.color_index = 8'd0;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid)
        begin
            busy_next = 1'b0;
        end
        if (tail.valid)
        begin
            count_next = tail.last ? '0 : cnt_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= tail.valid;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `CPI_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `CPI_ASSERT_IMP(a_done_idle, done, !busy)
    `CPI_ASSERT_IMP(a_ovf_excl, done && result.overflow, !result.new_entry && result.color_index == 8'd0)
    `CPI_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(PALETTE_DEPTH))

endmodule

>>> rtl/cpi_cell.sv
module cpi_cell
    import cpi_pkg::*;
#(
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 9,
    parameter int CELL_IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cpi_tok_t           tok_in,
    input  logic [IDX_W-1:0]   idx_in,
    input  logic [CNT_W-1:0]   count,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [COLOR_W-1:0] wr_color,
    output cpi_tok_t           tok_out,
    output logic [IDX_W-1:0]   idx_out
);

    logic [COLOR_W-1:0] entry_reg;
    logic               valid_reg;
    logic               hit_reg;
    logic               last_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic               active;
    logic               match;
    logic               hit_next;
    logic [IDX_W-1:0]   idx_next;

    assign active = count > CNT_W'(CELL_IDX);
    assign match  = tok_in.valid && active && (entry_reg == tok_in.color);

    always_comb
    begin
        hit_next = tok_in.hit;
        idx_next = idx_in;
        if (!tok_in.hit && match)
        begin
            hit_next = 1'b1;
            idx_next = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == IDX_W'(CELL_IDX)))
        begin
            entry_reg <= wr_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        last_reg  <= tok_in.last;
        color_reg <= tok_in.color;
        idx_reg   <= idx_next;
    end

    assign tok_out = '{valid: valid_reg, hit: hit_reg, last: last_reg, color: color_reg};
    assign idx_out = idx_reg;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cpi_pkg::*;

    localparam int PALETTE_DEPTH = 256;
    localparam int TARGET_ITEMS = 850;
    localparam int STALL_LIMIT = 4000;

    // palette predictor and queue of expected results
    class palette_scoreboard;
        bit [23:0] colors [PALETTE_DEPTH];
        int unsigned used;
        cpi_result_t pending[$];
        int error_count;

        function new();
            used = 0;
            error_count = 0;
        endfunction

        function void note_pixel(cpi_pixel_t p);
            bit [23:0] color;
            int found;
            cpi_result_t r;
            color = {p.pixel_red, p.pixel_green, p.pixel_blue};
            found = -1;
            r = '0;
            for (int j = 0; j < used; j++)
            begin
                if (colors[j] == color)
                begin
                    found = j;
                    break;
                end
            end
            if (found >= 0)
            begin
                r.color_index = found[7:0];
            end
            else if (used < PALETTE_DEPTH)
            begin
                colors[used] = color;
                r.color_index = used[7:0];
                used++;
                r.new_entry = 1'b1;
            end
            else
            begin
                r.overflow = 1'b1;
            end
            r.entry_count = used[8:0];
            r.last_result = p.last_pixel;
            if (p.last_pixel)
                used = 0;
            pending.push_back(r);
        endfunction

        function void check_result(cpi_result_t got);
            cpi_result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no pending item: %h", got);
                error_count++;
                return;
            end
            want = pending.pop_front();
            if (got.color_index !== want.color_index)
            begin
                $error("color_index expected %0d got %0d", want.color_index, got.color_index);
                error_count++;
            end
            if (got.new_entry !== want.new_entry)
            begin
                $error("new_entry expected %0d got %0d", want.new_entry, got.new_entry);
                error_count++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow expected %0d got %0d", want.overflow, got.overflow);
                error_count++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
                error_count++;
            end
            if (got.last_result !== want.last_result)
            begin
                $error("last_result expected %0d got %0d", want.last_result, got.last_result);
                error_count++;
            end
        endfunction

        function int pending_count();
            return pending.size();
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cpi_pixel_t pixel = '0;
    logic done;
    cpi_result_t result;

    palette_scoreboard board = new();
    int items_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    color_palette_indexer #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic cpi_pixel_t make_pixel(input bit [23:0] color, input bit last);
        cpi_pixel_t p;
        p.pixel_red = color[23:16];
        p.pixel_green = color[15:8];
        p.pixel_blue = color[7:0];
        p.last_pixel = last;
        return p;
    endfunction

    // bursts of items with random gaps that land on any phase of the lookup
    task automatic send_pixel(input cpi_pixel_t p);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 320);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        pixel <= p;
        do @(posedge clk); while (busy);
        board.note_pixel(p);
        items_sent++;
    endtask

    // fills the palette with distinct colors, then runs past the end if len exceeds PALETTE_DEPTH
    task automatic send_big_image(input int len);
        bit [23:0] seen [$];
        bit [23:0] color;
        for (int j = 0; j < len; j++)
        begin
            if (j < PALETTE_DEPTH)
            begin
                color = {16'($urandom_range(0, 16'hffff)), j[7:0]};
                seen.push_back(color);
            end
            else if ($urandom_range(0, 1) == 0)
                color = 24'($urandom_range(0, 24'hffffff));
            else
                color = seen[$urandom_range(0, seen.size() - 1)];
            send_pixel(make_pixel(color, j == len - 1));
        end
    endtask

    task automatic send_small_image(input int len);
        bit [23:0] pool [6];
        bit [23:0] color;
        bit last;
        foreach (pool[k])
            pool[k] = 24'($urandom_range(0, 24'hffffff));
        for (int j = 0; j < len; j++)
        begin
            if ($urandom_range(0, 9) == 0)
                color = 24'($urandom_range(0, 24'hffffff));
            else
                color = pool[$urandom_range(0, 5)];
            last = (j == len - 1) || ($urandom_range(0, 32) == 0);
            send_pixel(make_pixel(color, last));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, hits, end of image and reuse after clear
        send_pixel(make_pixel(24'h000000, 1'b0));
        send_pixel(make_pixel(24'hffffff, 1'b0));
        send_pixel(make_pixel(24'h000000, 1'b0));
        send_pixel(make_pixel(24'hffffff, 1'b0));
        send_pixel(make_pixel(24'hff0000, 1'b0));
        send_pixel(make_pixel(24'h00ff00, 1'b0));
        send_pixel(make_pixel(24'h0000ff, 1'b0));
        send_pixel(make_pixel(24'h00ff00, 1'b0));
        send_pixel(make_pixel(24'h0000ff, 1'b1));
        send_pixel(make_pixel(24'h0000ff, 1'b0));
        send_pixel(make_pixel(24'h000000, 1'b1));
        send_pixel(make_pixel(24'hffffff, 1'b1));
        send_pixel(make_pixel(24'haa55aa, 1'b0));
        send_pixel(make_pixel(24'h55aa55, 1'b0));
        send_pixel(make_pixel(24'h010101, 1'b0));
        send_pixel(make_pixel(24'h55aa55, 1'b0));
        send_pixel(make_pixel(24'hfefefe, 1'b1));

        // full palette with overflow, then one ending near the full mark
        send_big_image(PALETTE_DEPTH + $urandom_range(20, 40));
        send_big_image($urandom_range(PALETTE_DEPTH - 6, PALETTE_DEPTH + 6));

        while (items_sent < TARGET_ITEMS)
            send_small_image($urandom_range(1, 40));

        start <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (PALETTE_DEPTH + 8) @(posedge clk);

        if (board.error_count == 0 && board.pending_count() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
